FILE: rtl/ecrp_pkg.sv
// ----------------------------------------------------------------------------
// ecrp_pkg
// Types and constants shared by the EEPROM command register port.
// ----------------------------------------------------------------------------
package ecrp_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] word_type;
   typedef logic [9:0]  cmd_addr_type;

   // Bus access kinds.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Port numbers.
   localparam byte_type PORT_DATA_LO = 8'hBA;
   localparam byte_type PORT_DATA_HI = 8'hBB;
   localparam byte_type PORT_ADDR_LO = 8'hBC;
   localparam byte_type PORT_ADDR_HI = 8'hBD;
   localparam byte_type PORT_COMMAND = 8'hBE;

   // Action bits of the command byte.
   localparam int CMD_SUB_BIT   = 6;
   localparam int CMD_WRITE_BIT = 5;
   localparam int CMD_READ_BIT  = 4;

   // Subcommands.
   localparam logic [1:0] CMD_NONE    = 2'd0;
   localparam logic [1:0] SUB_ENABLE  = 2'd3;
   localparam logic [1:0] SUB_DISABLE = 2'd0;

   // Acknowledge bits returned on a command port read.
   localparam byte_type ACK_WRITE = 8'h02;
   localparam byte_type ACK_READ  = 8'h01;
   localparam byte_type ACK_IDLE  = 8'h03;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_LOAD
   } ecrp_state_type;

   typedef enum logic [1:0] {
      MEM_NONE,
      MEM_WRITE,
      MEM_READ
   } ecrp_mem_op_type;

endpackage

FILE: rtl/ecrp_if.sv
// ----------------------------------------------------------------------------
// ecrp_if
// Handshake channels of the EEPROM command register port.
// ----------------------------------------------------------------------------
interface ecrp_req_if;
   import ecrp_pkg::*;
   logic     valid;
   logic     ready;
   logic     operation;
   byte_type port;
   byte_type write_byte;
   modport source (output valid, output operation, output port, output write_byte,
                   input ready);
   modport sink (input valid, input operation, input port, input write_byte,
                 output ready);
endinterface

interface ecrp_rsp_if;
   import ecrp_pkg::*;
   logic     valid;
   logic     ready;
   byte_type read_byte;
   modport source (output valid, output read_byte, input ready);
   modport sink (input valid, input read_byte, output ready);
endinterface

interface ecrp_csr_if;
   logic valid;
   logic ready;
   logic color_mode;
   modport source (output valid, output color_mode, input ready);
   modport sink (input valid, input color_mode, output ready);
endinterface

FILE: rtl/eeprom_command_register_port.sv
// ----------------------------------------------------------------------------
// eeprom_command_register_port
// Byte-wide register front end of an internal 16-bit-word EEPROM.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                           Handshake
//  req_bus   in         operation, port, write_byte       valid / ready
//  rsp_bus   out        read_byte                         valid / ready
//  csr_bus   in         color_mode                        valid / ready
//
// A register access is answered in the next cycle; its read data is registered and held
// until taken, and the next request is accepted once the output is free.
// A store write command passes through ST_REDUCE, which subtracts STORE_WORDS
// from the address until it lies in the store, and then writes; a store read
// goes on to ST_LOAD to take the registered data of the single RAM port.
// After reset the store is cleared one word at a time, during which
// no request is accepted; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module eeprom_command_register_port #(
   parameter int STORE_WORDS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   ecrp_req_if.sink    req_bus,
   ecrp_rsp_if.source  rsp_bus,
   ecrp_csr_if.sink    csr_bus
);
   import ecrp_pkg::*;

   localparam int                 AW         = $clog2(STORE_WORDS);
   localparam logic [AW-1:0]      CLEAR_LAST = AW'(STORE_WORDS - 1);
   localparam logic [10:0]        STORE_LIM  = 11'(STORE_WORDS);
   localparam cmd_addr_type       STORE_STEP = 10'(STORE_WORDS);

   ecrp_state_type  state_ff, state_in;
   ecrp_mem_op_type mem_op_ff, mem_op_in;
   logic [AW-1:0]   clr_ff, clr_in;
   cmd_addr_type    addr_ff, addr_in;
   word_type        data_buffer_ff, data_buffer_in;
   byte_type        addr_lo_ff, addr_lo_in;
   byte_type        addr_hi_ff, addr_hi_in;
   byte_type        cmd_ff, cmd_in;
   logic            allow_ff, allow_in;
   logic            color_mode_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   byte_type        rsp_byte_ff, rsp_byte_in;

   logic            accept;
   logic            ram_wr_en;
   logic [AW-1:0]   ram_addr;
   word_type        ram_wr_data;
   word_type        ram_rd_data;

   logic [15:0]     sel;
   logic [1:0]      dec_command;
   logic [1:0]      dec_sub;
   cmd_addr_type    dec_addr;
   byte_type        cmd_read;

   ecrp_ram #(
      .WIDTH (16),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.read_byte = rsp_byte_ff;

   // Split the latched address/command word according to the decode mode.
   always_comb begin
      sel = {addr_hi_ff, addr_lo_ff};
      if (color_mode_ff) begin
         dec_command = sel[11:10];
         dec_sub     = sel[9:8];
         dec_addr    = sel[9:0];
      end else begin
         dec_command = sel[7:6];
         dec_sub     = sel[5:4];
         dec_addr    = {4'b0000, sel[5:0]};
      end
   end

   always_comb begin
      if (cmd_ff[CMD_WRITE_BIT]) begin
         cmd_read = cmd_ff | ACK_WRITE;
      end else if (cmd_ff[CMD_READ_BIT]) begin
         cmd_read = cmd_ff | ACK_READ;
      end else begin
         cmd_read = cmd_ff | ACK_IDLE;
      end
   end

   always_comb begin
      state_in       = state_ff;
      mem_op_in      = mem_op_ff;
      clr_in         = clr_ff;
      addr_in        = addr_ff;
      data_buffer_in = data_buffer_ff;
      addr_lo_in     = addr_lo_ff;
      addr_hi_in     = addr_hi_ff;
      cmd_in         = cmd_ff;
      allow_in       = allow_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_byte_in    = rsp_byte_ff;
      ram_wr_en      = 1'b0;
      ram_addr       = addr_ff[AW-1:0];
      ram_wr_data    = data_buffer_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_addr    = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == CLEAR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = '0;
               if (req_bus.operation == OP_WRITE) begin
                  unique case (req_bus.port)
                     PORT_DATA_LO: data_buffer_in[7:0]  = req_bus.write_byte;
                     PORT_DATA_HI: data_buffer_in[15:8] = req_bus.write_byte;
                     PORT_ADDR_LO: addr_lo_in = req_bus.write_byte;
                     PORT_ADDR_HI: addr_hi_in = req_bus.write_byte;
                     PORT_COMMAND: begin
                        cmd_in  = req_bus.write_byte;
                        addr_in = dec_addr;
                        if (req_bus.write_byte[CMD_SUB_BIT]) begin
                           if (dec_command == CMD_NONE) begin
                              if (dec_sub == SUB_ENABLE) begin
                                 allow_in = 1'b1;
                              end else if (dec_sub == SUB_DISABLE) begin
                                 allow_in = 1'b0;
                              end
                           end
                        end else if (req_bus.write_byte[CMD_WRITE_BIT]) begin
                           if (allow_ff) begin
                              mem_op_in = MEM_WRITE;
                              state_in  = ST_REDUCE;
                           end
                        end else if (req_bus.write_byte[CMD_READ_BIT]) begin
                           mem_op_in = MEM_READ;
                           state_in  = ST_REDUCE;
                        end
                     end
                     default: ;
                  endcase
               end else begin
                  unique case (req_bus.port)
                     PORT_DATA_LO: rsp_byte_in = data_buffer_ff[7:0];
                     PORT_DATA_HI: rsp_byte_in = data_buffer_ff[15:8];
                     PORT_COMMAND: rsp_byte_in = cmd_read;
                     default:      rsp_byte_in = '0;
                  endcase
               end
            end
         end
         ST_REDUCE: begin
            // Wrap the address one subtraction a cycle, then touch the store.
            if ({1'b0, addr_ff} >= STORE_LIM) begin
               addr_in = addr_ff - STORE_STEP;
            end else if (mem_op_ff == MEM_WRITE) begin
               ram_wr_en = 1'b1;
               mem_op_in = MEM_NONE;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            data_buffer_in = ram_rd_data;
            mem_op_in      = MEM_NONE;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         mem_op_ff      <= MEM_NONE;
         clr_ff         <= '0;
         addr_ff        <= '0;
         data_buffer_ff <= '0;
         addr_lo_ff     <= '0;
         addr_hi_ff     <= '0;
         cmd_ff         <= '0;
         allow_ff       <= 1'b0;
         color_mode_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         mem_op_ff      <= mem_op_in;
         clr_ff         <= clr_in;
         addr_ff        <= addr_in;
         data_buffer_ff <= data_buffer_in;
         addr_lo_ff     <= addr_lo_in;
         addr_hi_ff     <= addr_hi_in;
         cmd_ff         <= cmd_in;
         allow_ff       <= allow_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_bus.valid) begin
            color_mode_ff <= csr_bus.color_mode;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
   end

endmodule

FILE: rtl/ecrp_ram.sv
// ----------------------------------------------------------------------------
// ecrp_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module ecrp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule
